/* hdl/lavm_pkg.sv */
// ----------------------------------------------------------------------------
// lavm_pkg
// shared types and constants of the look-at view matrix generator
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  // configuration register indexes
  localparam logic [1:0] REG_UP_X = 2'd0;
  localparam logic [1:0] REG_UP_Y = 2'd1;
  localparam logic [1:0] REG_UP_Z = 2'd2;

  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SCALE,
    N_SQUARE,
    N_ROOT,
    N_DIV_LOAD,
    N_DIVIDE
  } norm_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_NORM_UP,
    B_NORM_FWD,
    B_CROSS_R,
    B_NORM_R,
    B_CROSS_U,
    B_NORM_U,
    B_TRANS,
    B_PUSH
  } back_state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* hdl/lavm_fifo.sv */
// ----------------------------------------------------------------------------
// lavm_fifo
// short register queue between the front and back parts
// ----------------------------------------------------------------------------
module lavm_fifo #(
  parameter int W     = 195,
  parameter int DEPTH = lavm_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [W-1:0]          din,
  input  logic                  pop,
  output logic [W-1:0]          dout,
  output lavm_pkg::fifo_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  assign dout       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

/* hdl/lavm_front.sv */
// ----------------------------------------------------------------------------
// lavm_front
// takes camera beats, forms eye minus aim and queues the item
// ----------------------------------------------------------------------------
module lavm_front #(
  parameter int COORD_WIDTH = lavm_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_WIDTH-1:0]      in_eye_x,
  input  logic signed [COORD_WIDTH-1:0]      in_eye_y,
  input  logic signed [COORD_WIDTH-1:0]      in_eye_z,
  input  logic signed [COORD_WIDTH-1:0]      in_aim_x,
  input  logic signed [COORD_WIDTH-1:0]      in_aim_y,
  input  logic signed [COORD_WIDTH-1:0]      in_aim_z,
  input  lavm_pkg::fifo_stat_t               fifo_stat,
  output logic                               push,
  output logic [6*COORD_WIDTH+2:0]           item
);

  localparam int CW = COORD_WIDTH;

  logic                 stg_valid_r;
  logic [CW-1:0]        eye_r [3];
  logic signed [CW:0]   diff_r [3];
  logic                 take;

  assign in_stall = stg_valid_r && fifo_stat.full;
  assign take     = in_valid && !in_stall;
  assign push     = stg_valid_r && !fifo_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (take) begin
      stg_valid_r <= 1'b1;
    end else if (push) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      eye_r[0]  <= in_eye_x;
      eye_r[1]  <= in_eye_y;
      eye_r[2]  <= in_eye_z;
      diff_r[0] <= (CW+1)'(in_eye_x) - (CW+1)'(in_aim_x);
      diff_r[1] <= (CW+1)'(in_eye_y) - (CW+1)'(in_aim_y);
      diff_r[2] <= (CW+1)'(in_eye_z) - (CW+1)'(in_aim_z);
    end
  end

  assign item = {eye_r[0], eye_r[1], eye_r[2], diff_r[0], diff_r[1], diff_r[2]};

endmodule

/* hdl/lavm_norm.sv */
// ----------------------------------------------------------------------------
// lavm_norm
// multi-cycle vector normalizer: range scaling, sum of squares,
// bit-serial square root and one restoring divide per component
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF,
  parameter int MAG_W     = 33
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [MAG_W:0]        vin [3],
  output logic signed [FRAC_BITS+1:0]  nvec [3],
  output lavm_pkg::norm_stat_t         stat
);

  localparam int F     = FRAC_BITS;
  localparam int NUM_W = 31 + F;
  localparam int CNT_W = $clog2(F + 1);

  lavm_pkg::norm_state_t state_r, state_nxt;

  logic             neg_r [3];
  logic [MAG_W-1:0] mag_r [3];
  logic [MAG_W-1:0] m_r;
  logic [61:0]      sum_r;
  logic [62:0]      rn_r, res_r, bit_r;
  logic [31:0]      len_r;
  logic [32:0]      rem_r;
  logic [F:0]       low_r;
  logic [F:0]       q_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       idx_r;
  logic             done_r, zero_r;

  logic             vneg [3];
  logic [MAG_W-1:0] vmag [3];
  logic [MAG_W-1:0] vmax;
  logic             in_range;
  logic [59:0]      sq;
  logic [62:0]      root_try;
  logic             root_ge;
  logic [NUM_W-1:0] num;
  logic [32:0]      rem2;
  logic             div_ge;
  logic [F:0]       q_fin;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vneg[i] = vin[i][MAG_W];
      vmag[i] = vneg[i] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
    end
    vmax = (vmag[0] > vmag[1]) ? vmag[0] : vmag[1];
    if (vmag[2] > vmax) vmax = vmag[2];
  end

  assign in_range = ((m_r >> 30) == '0) && ((m_r >> 29) != '0);
  assign sq       = mag_r[idx_r][29:0] * mag_r[idx_r][29:0];
  assign root_try = res_r + bit_r;
  assign root_ge  = (rn_r >= root_try);
  // rounded dividend: magnitude in fixed point plus half the length
  assign num      = {1'b0, mag_r[idx_r][29:0], {F{1'b0}}} + NUM_W'(len_r >> 1);
  assign rem2     = {rem_r[31:0], low_r[F]};
  assign div_ge   = (rem2 >= {1'b0, len_r});
  assign q_fin    = {q_r[F-1:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lavm_pkg::N_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lavm_pkg::N_IDLE:     if (start && vmax != '0) state_nxt = lavm_pkg::N_SCALE;
      lavm_pkg::N_SCALE:    if (in_range) state_nxt = lavm_pkg::N_SQUARE;
      lavm_pkg::N_SQUARE:   if (idx_r == 2'd2) state_nxt = lavm_pkg::N_ROOT;
      lavm_pkg::N_ROOT:     if (bit_r[0]) state_nxt = lavm_pkg::N_DIV_LOAD;
      lavm_pkg::N_DIV_LOAD: state_nxt = lavm_pkg::N_DIVIDE;
      lavm_pkg::N_DIVIDE: begin
        if (cnt_r == '0)
          state_nxt = (idx_r == 2'd2) ? lavm_pkg::N_IDLE : lavm_pkg::N_DIV_LOAD;
      end
      default: state_nxt = lavm_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (state_r == lavm_pkg::N_IDLE && start) begin
        done_r <= (vmax == '0);
        zero_r <= (vmax == '0);
      end else if (state_r == lavm_pkg::N_DIVIDE && cnt_r == '0 && idx_r == 2'd2) begin
        done_r <= 1'b1;
        zero_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      lavm_pkg::N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vneg[i];
            mag_r[i] <= vmag[i];
            if (vmax == '0) nvec[i] <= '0;
          end
          m_r <= vmax;
        end
      end
      lavm_pkg::N_SCALE: begin
        // big jumps of eight where the whole jump stays outside the window
        if ((m_r >> 30) != '0) begin
          if ((m_r >> 37) != '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 8;
            m_r <= m_r >> 8;
          end else begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
            m_r <= m_r >> 1;
          end
        end else if ((m_r >> 29) == '0) begin
          if ((m_r >> 21) == '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 8;
            m_r <= m_r << 8;
          end else begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
            m_r <= m_r << 1;
          end
        end else begin
          idx_r <= 2'd0;
          sum_r <= '0;
        end
      end
      lavm_pkg::N_SQUARE: begin
        sum_r <= sum_r + 62'(sq);
        idx_r <= idx_r + 1'b1;
        if (idx_r == 2'd2) begin
          rn_r  <= 63'(sum_r) + 63'(sq);
          res_r <= '0;
          bit_r <= 63'(1) << 62;
        end
      end
      lavm_pkg::N_ROOT: begin
        if (root_ge) begin
          rn_r  <= rn_r - root_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          len_r <= root_ge ? 32'((res_r >> 1) + bit_r) : 32'(res_r >> 1);
          idx_r <= 2'd0;
        end
      end
      lavm_pkg::N_DIV_LOAD: begin
        rem_r <= 33'(num[NUM_W-1:F+1]);
        low_r <= num[F:0];
        q_r   <= '0;
        cnt_r <= CNT_W'(F);
      end
      lavm_pkg::N_DIVIDE: begin
        rem_r <= div_ge ? rem2 - {1'b0, len_r} : rem2;
        q_r   <= q_fin;
        low_r <= low_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          nvec[idx_r] <= neg_r[idx_r] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
          idx_r       <= idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign stat.done = done_r;
  assign stat.zero = zero_r;

endmodule

/* hdl/lavm_back.sv */
// ----------------------------------------------------------------------------
// lavm_back
// builds the basis vectors and translations of one queued item and
// sends the four matrix rows from a result buffer
// ----------------------------------------------------------------------------
module lavm_back #(
  parameter int FRAC_BITS   = lavm_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = lavm_pkg::COORD_WIDTH_DEF,
  parameter int MAG_W       = 33,
  parameter int ACC_W       = 35
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [6*COORD_WIDTH+2:0]           item,
  input  lavm_pkg::fifo_stat_t               fifo_stat,
  output logic                               pop,
  input  logic [COORD_WIDTH-1:0]             up [3],
  output logic                               norm_start,
  output logic signed [MAG_W:0]              norm_vin [3],
  input  logic signed [FRAC_BITS+1:0]        norm_n [3],
  input  lavm_pkg::norm_stat_t               norm_stat,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_row_number,
  output logic signed [COORD_WIDTH-1:0]      out_col_zero,
  output logic signed [COORD_WIDTH-1:0]      out_col_one,
  output logic signed [COORD_WIDTH-1:0]      out_col_two,
  output logic signed [COORD_WIDTH-1:0]      out_col_three,
  output logic                               out_degenerate,
  output logic                               out_last_row
);

  localparam int F     = FRAC_BITS;
  localparam int CW    = COORD_WIDTH;
  localparam int NW    = F + 2;
  localparam int MUL_W = (F + 2 > CW - F) ? F + 2 : CW - F;
  localparam int SW    = ACC_W + 2;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SW-1:0] ONE_W  = SW'(1) << F;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);

  function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] x);
    if (x > SAT_HI)      return SAT_HI[CW-1:0];
    else if (x < SAT_LO) return SAT_LO[CW-1:0];
    else                 return x[CW-1:0];
  endfunction

  lavm_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0]            eye_r [3];
  logic signed [CW:0]       diff_r [3];
  logic signed [NW-1:0]     nu_r [3];
  logic signed [NW-1:0]     nf_r [3];
  logic signed [NW-1:0]     nr_r [3];
  logic signed [NW-1:0]     nv_r [3];
  logic signed [ACC_W-1:0]  c_r [3];
  logic signed [ACC_W-1:0]  acc_a_r, acc_b_r;
  logic signed [2*MUL_W-1:0] prod_r;
  logic [CW-1:0]            tr_r [3];
  logic [2:0]               step_r;
  logic                     phase_r;
  logic [1:0]               row_r;
  logic                     degen_r;
  logic                     started_r;

  logic                     ob_valid_r;
  logic [1:0]               ob_cnt_r;
  logic signed [NW-1:0]     ob_rot_r [3][3];
  logic [CW-1:0]            ob_tr_r [3];
  logic                     ob_degen_r;
  logic                     ob_free;

  logic                     in_norm;
  logic                     cross_sel;
  logic [1:0]               k, ia, ib, p, q;
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [NW-1:0]     nsel;
  logic signed [ACC_W-1:0]  prod_w;
  logic signed [ACC_W-1:0]  b_round;
  logic signed [SW-1:0]     tsum;

  assign in_norm = (state_r == lavm_pkg::B_NORM_UP) || (state_r == lavm_pkg::B_NORM_FWD) ||
                   (state_r == lavm_pkg::B_NORM_R)  || (state_r == lavm_pkg::B_NORM_U);
  assign norm_start = in_norm && !started_r;
  assign cross_sel  = (state_r == lavm_pkg::B_CROSS_U);
  assign pop        = (state_r == lavm_pkg::B_IDLE) && !fifo_stat.empty;
  assign ob_free    = !ob_valid_r || (!out_stall && ob_cnt_r == lavm_pkg::ROW_LAST);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (state_r)
        lavm_pkg::B_NORM_UP:  norm_vin[i] = (MAG_W+1)'($signed(up[i]));
        lavm_pkg::B_NORM_FWD: norm_vin[i] = (MAG_W+1)'(diff_r[i]);
        default:              norm_vin[i] = (MAG_W+1)'(c_r[i]);
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    k = step_r[2:1];
    case (k)
      2'd0:    begin p = 2'd1; q = 2'd2; end
      2'd1:    begin p = 2'd2; q = 2'd0; end
      default: begin p = 2'd0; q = 2'd1; end
    endcase
    ia = step_r[0] ? q : p;
    ib = step_r[0] ? p : q;
    if (state_r == lavm_pkg::B_TRANS) begin
      ia = (k == 2'd3) ? 2'd0 : k;
      case (row_r)
        2'd0:    nsel = nr_r[ia];
        2'd1:    nsel = nv_r[ia];
        default: nsel = nf_r[ia];
      endcase
      ma = MUL_W'(nsel);
      if (step_r[0]) mb = MUL_W'({1'b0, eye_r[ia][F-1:0]});
      else           mb = MUL_W'($signed(eye_r[ia][CW-1:F]));
    end else begin
      nsel = cross_sel ? nf_r[ia] : nu_r[ia];
      ma   = MUL_W'(nsel);
      mb   = MUL_W'(cross_sel ? nr_r[ib] : nf_r[ib]);
    end
  end

  assign prod_w  = ACC_W'(prod_r);
  assign b_round = (acc_b_r + HALF) >>> F;
  assign tsum    = -(SW'(acc_a_r) + SW'(b_round));

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lavm_pkg::B_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lavm_pkg::B_IDLE:     if (!fifo_stat.empty) state_nxt = lavm_pkg::B_NORM_UP;
      lavm_pkg::B_NORM_UP:  if (norm_stat.done) state_nxt = lavm_pkg::B_NORM_FWD;
      lavm_pkg::B_NORM_FWD: if (norm_stat.done) state_nxt = lavm_pkg::B_CROSS_R;
      lavm_pkg::B_CROSS_R:  if (phase_r && step_r == 3'd5) state_nxt = lavm_pkg::B_NORM_R;
      lavm_pkg::B_NORM_R:   if (norm_stat.done) state_nxt = lavm_pkg::B_CROSS_U;
      lavm_pkg::B_CROSS_U:  if (phase_r && step_r == 3'd5) state_nxt = lavm_pkg::B_NORM_U;
      lavm_pkg::B_NORM_U:   if (norm_stat.done) state_nxt = lavm_pkg::B_TRANS;
      lavm_pkg::B_TRANS:    if (step_r == 3'd6 && row_r == 2'd2) state_nxt = lavm_pkg::B_PUSH;
      lavm_pkg::B_PUSH:     if (ob_free) state_nxt = lavm_pkg::B_IDLE;
      default:              state_nxt = lavm_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      step_r    <= '0;
      phase_r   <= 1'b0;
      row_r     <= '0;
    end else begin
      if (norm_start)          started_r <= 1'b1;
      else if (norm_stat.done) started_r <= 1'b0;
      if (in_norm) begin
        step_r  <= '0;
        phase_r <= 1'b0;
        row_r   <= '0;
      end else if (state_r == lavm_pkg::B_CROSS_R || state_r == lavm_pkg::B_CROSS_U ||
                   state_r == lavm_pkg::B_TRANS) begin
        if (step_r == 3'd6) begin
          step_r <= '0;
          row_r  <= row_r + 1'b1;
        end else begin
          phase_r <= !phase_r;
          if (phase_r) step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (state_r)
      lavm_pkg::B_IDLE: begin
        if (pop) begin
          eye_r[0]  <= item[6*CW+2 -: CW];
          eye_r[1]  <= item[5*CW+2 -: CW];
          eye_r[2]  <= item[4*CW+2 -: CW];
          diff_r[0] <= $signed(item[3*CW+2 -: CW+1]);
          diff_r[1] <= $signed(item[2*CW+1 -: CW+1]);
          diff_r[2] <= $signed(item[CW:0]);
          degen_r   <= 1'b0;
        end
      end
      lavm_pkg::B_NORM_UP: if (norm_stat.done) nu_r <= norm_n;
      lavm_pkg::B_NORM_FWD: begin
        if (norm_stat.done) begin
          nf_r    <= norm_n;
          degen_r <= degen_r | norm_stat.zero;
        end
      end
      lavm_pkg::B_NORM_R: begin
        if (norm_stat.done) begin
          nr_r    <= norm_n;
          degen_r <= degen_r | norm_stat.zero;
        end
      end
      lavm_pkg::B_NORM_U: begin
        if (norm_stat.done) begin
          nv_r    <= norm_n;
          degen_r <= degen_r | norm_stat.zero;
        end
      end
      lavm_pkg::B_CROSS_R, lavm_pkg::B_CROSS_U: begin
        if (phase_r) begin
          if (!step_r[0]) acc_a_r <= prod_w;
          else            c_r[k]  <= acc_a_r - prod_w;
        end
      end
      lavm_pkg::B_TRANS: begin
        if (step_r == 3'd6) begin
          tr_r[row_r] <= sat(tsum);
        end else if (phase_r) begin
          case (step_r)
            3'd0:    acc_a_r <= prod_w;
            3'd1:    acc_b_r <= prod_w;
            default: begin
              if (step_r[0]) acc_b_r <= acc_b_r + prod_w;
              else           acc_a_r <= acc_a_r + prod_w;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // result buffer, drained one row per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      ob_cnt_r   <= '0;
    end else begin
      if (ob_valid_r && !out_stall) begin
        ob_cnt_r <= ob_cnt_r + 1'b1;
        if (ob_cnt_r == lavm_pkg::ROW_LAST) ob_valid_r <= 1'b0;
      end
      if (state_r == lavm_pkg::B_PUSH && ob_free) begin
        ob_valid_r <= 1'b1;
        ob_cnt_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lavm_pkg::B_PUSH && ob_free) begin
      ob_rot_r[0] <= nr_r;
      ob_rot_r[1] <= nv_r;
      ob_rot_r[2] <= nf_r;
      ob_tr_r     <= tr_r;
      ob_degen_r  <= degen_r;
    end
  end

  always_comb begin
    case (ob_cnt_r)
      2'd0, 2'd1, 2'd2: begin
        out_col_zero  = sat(SW'(ob_rot_r[ob_cnt_r][0]));
        out_col_one   = sat(SW'(ob_rot_r[ob_cnt_r][1]));
        out_col_two   = sat(SW'(ob_rot_r[ob_cnt_r][2]));
        out_col_three = sat(SW'($signed(ob_tr_r[ob_cnt_r])));
      end
      default: begin
        out_col_zero  = '0;
        out_col_one   = '0;
        out_col_two   = '0;
        out_col_three = sat(ONE_W);
      end
    endcase
  end

  assign out_valid      = ob_valid_r;
  assign out_row_number = ob_cnt_r;
  assign out_degenerate = ob_degen_r;
  assign out_last_row   = (ob_cnt_r == lavm_pkg::ROW_LAST);

endmodule

/* hdl/look_at_view_matrix_top.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// look-at view matrix generator, fixed point, four row beats per camera
// ----------------------------------------------------------------------------
// usage:
//   input channel: one beat carries eye and aim points (signed fixed point).
//   result channel: four beats per input, rows 0 to 3 in order; row 3 is
//   0 0 0 1 and carries last_row. degenerate is the same on all four rows.
//   config port: write up_x, up_y, up_z by index while the block is idle.
// timing:
//   the front stage takes a beat each cycle while the two-entry queue has
//   room, so up to three cameras can wait while one matrix is built.
//   the four normalize passes share one unit with a 32-step bit-serial
//   square root and a one-bit-per-cycle divider, and that unit sets the
//   rate.
// reset:
//   synchronous active-low reset empties the queue and result buffer and
//   sets up to (0, 1.0, 0).
// stall:
//   a stalled row holds; the next matrix waits in the back part until the
//   buffer frees, and the queue fills before in_stall rises.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top #(
  parameter int FRAC_BITS   = lavm_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = lavm_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_eye_x,
  input  logic signed [COORD_WIDTH-1:0] in_eye_y,
  input  logic signed [COORD_WIDTH-1:0] in_eye_z,
  input  logic signed [COORD_WIDTH-1:0] in_aim_x,
  input  logic signed [COORD_WIDTH-1:0] in_aim_y,
  input  logic signed [COORD_WIDTH-1:0] in_aim_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_row_number,
  output logic signed [COORD_WIDTH-1:0] out_col_zero,
  output logic signed [COORD_WIDTH-1:0] out_col_one,
  output logic signed [COORD_WIDTH-1:0] out_col_two,
  output logic signed [COORD_WIDTH-1:0] out_col_three,
  output logic                          out_degenerate,
  output logic                          out_last_row
);

  localparam int F      = FRAC_BITS;
  localparam int CW     = COORD_WIDTH;
  localparam int MAG_A  = (CW + 1 > 2 * F + 2) ? CW + 1 : 2 * F + 2;
  localparam int MAG_W  = (MAG_A > 31) ? MAG_A : 31;
  localparam int ACC_W  = (CW + 3 > 2 * F + 4) ? CW + 3 : 2 * F + 4;
  localparam int ITEM_W = 6 * CW + 3;

  logic [CW-1:0]            up_r [3];
  lavm_pkg::fifo_stat_t     fifo_stat;
  lavm_pkg::norm_stat_t     norm_stat;
  logic                     push, pop;
  logic [ITEM_W-1:0]        item_in, item_out;
  logic                     norm_start;
  logic signed [MAG_W:0]    norm_vin [3];
  logic signed [F+1:0]      norm_n [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r[0] <= '0;
      up_r[1] <= CW'(1) << F;
      up_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lavm_pkg::REG_UP_X: up_r[0] <= cfg_data;
        lavm_pkg::REG_UP_Y: up_r[1] <= cfg_data;
        lavm_pkg::REG_UP_Z: up_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  lavm_front #(.COORD_WIDTH(CW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_eye_x  (in_eye_x),
    .in_eye_y  (in_eye_y),
    .in_eye_z  (in_eye_z),
    .in_aim_x  (in_aim_x),
    .in_aim_y  (in_aim_y),
    .in_aim_z  (in_aim_z),
    .fifo_stat (fifo_stat),
    .push      (push),
    .item      (item_in)
  );

  lavm_fifo #(.W(ITEM_W), .DEPTH(lavm_pkg::QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (item_in),
    .pop   (pop),
    .dout  (item_out),
    .stat  (fifo_stat)
  );

  lavm_norm #(.FRAC_BITS(F), .MAG_W(MAG_W)) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vin   (norm_vin),
    .nvec  (norm_n),
    .stat  (norm_stat)
  );

  lavm_back #(
    .FRAC_BITS   (F),
    .COORD_WIDTH (CW),
    .MAG_W       (MAG_W),
    .ACC_W       (ACC_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item_out),
    .fifo_stat      (fifo_stat),
    .pop            (pop),
    .up             (up_r),
    .norm_start     (norm_start),
    .norm_vin       (norm_vin),
    .norm_n         (norm_n),
    .norm_stat      (norm_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_number (out_row_number),
    .out_col_zero   (out_col_zero),
    .out_col_one    (out_col_one),
    .out_col_two    (out_col_two),
    .out_col_three  (out_col_three),
    .out_degenerate (out_degenerate),
    .out_last_row   (out_last_row)
  );

`ifndef NO_ASSERTIONS
  // rows of one matrix follow in order
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_row) |=>
      (out_valid && out_row_number == $past(out_row_number) + 2'd1))
    else $error("matrix rows out of order");

  // the degenerate flag holds across the rows of one matrix
  a_degen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_row) |=> (out_degenerate == $past(out_degenerate)))
    else $error("degenerate flag changed inside a matrix");

  // a new burst of rows always opens on row 0
  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_row_number == 2'd0))
    else $error("row burst did not start at row 0");
`endif

endmodule
